[design/kcut_pkg.sv]
// ----------------------------------------------------------------------------
// Keyed counter table package
// Word types, status codes and the token that moves along the cell chain.
// ----------------------------------------------------------------------------
package kcut_pkg;

   localparam int KEY_W   = 16;
   localparam int COUNT_W = 16;
   localparam int VALUE_W = 22;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NEW     = 2'd1,
      ST_FULL    = 2'd2,
      ST_INVALID = 2'd3
   } kcut_status_type;

   typedef struct packed {
      logic                      func;
      logic [KEY_W-1:0]          key_a;
      logic [KEY_W-1:0]          key_b;
      logic signed [COUNT_W-1:0] delta;
   } kcut_req_type;

   typedef struct packed {
      kcut_status_type    status;
      logic [VALUE_W-1:0] value;
   } kcut_rsp_type;

   // One request in flight along the chain. While done is low, value holds
   // the running sum of a sum query.
   typedef struct packed {
      logic                      valid;
      logic                      done;
      logic                      func;
      logic [KEY_W-1:0]          key_a;
      logic [KEY_W-1:0]          key_b;
      logic signed [COUNT_W-1:0] delta;
      kcut_status_type           status;
      logic [VALUE_W-1:0]        value;
   } kcut_token_type;

endpackage

[design/kcut_cell.sv]
// ----------------------------------------------------------------------------
// Keyed counter table cell
// Holds one entry and serves the request token as it passes by.
// ----------------------------------------------------------------------------
module kcut_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  kcut_pkg::kcut_token_type tok_in,
   output kcut_pkg::kcut_token_type tok_out
);

   logic [kcut_pkg::KEY_W-1:0]   key_a_ff, key_a_in;
   logic [kcut_pkg::KEY_W-1:0]   key_b_ff, key_b_in;
   logic [kcut_pkg::COUNT_W-1:0] count_ff, count_in;
   kcut_pkg::kcut_token_type     tok_ff, tok_in_next;

   logic                             empty;
   logic signed [kcut_pkg::COUNT_W+1:0] upd_sum;
   logic [kcut_pkg::COUNT_W-1:0]     upd_count;
   logic [kcut_pkg::COUNT_W-1:0]     new_count;
   logic [kcut_pkg::VALUE_W:0]       add_sum;
   logic [kcut_pkg::VALUE_W-1:0]     sat_sum;

   assign empty = (key_b_ff == '0);

   always_comb begin
      upd_sum = $signed({2'b00, count_ff})
              + $signed({{2{tok_in.delta[kcut_pkg::COUNT_W-1]}}, tok_in.delta});
      if (upd_sum[kcut_pkg::COUNT_W+1]) begin
         upd_count = '0;
      end else if (upd_sum[kcut_pkg::COUNT_W]) begin
         upd_count = kcut_pkg::COUNT_MAX;
      end else begin
         upd_count = upd_sum[kcut_pkg::COUNT_W-1:0];
      end
      new_count = tok_in.delta[kcut_pkg::COUNT_W-1] ? '0 : tok_in.delta;
      add_sum = {1'b0, tok_in.value}
              + {{(kcut_pkg::VALUE_W+1-kcut_pkg::COUNT_W){1'b0}}, count_ff};
      sat_sum = add_sum[kcut_pkg::VALUE_W] ? kcut_pkg::VALUE_MAX
                                           : add_sum[kcut_pkg::VALUE_W-1:0];
   end

   // Entries fill from the low end and are never removed, so the first empty
   // cell reached by an unmatched add is the lowest empty entry.
   always_comb begin
      key_a_in    = key_a_ff;
      key_b_in    = key_b_ff;
      count_in    = count_ff;
      tok_in_next = tok_in;
      if (tok_in.valid && !tok_in.done) begin
         if (tok_in.func == kcut_pkg::FUNC_ADD) begin
            if (empty) begin
               key_a_in           = tok_in.key_a;
               key_b_in           = tok_in.key_b;
               count_in           = new_count;
               tok_in_next.done   = 1'b1;
               tok_in_next.status = kcut_pkg::ST_NEW;
               tok_in_next.value  = {{(kcut_pkg::VALUE_W-kcut_pkg::COUNT_W){1'b0}},
                                     new_count};
            end else if (key_a_ff == tok_in.key_a && key_b_ff == tok_in.key_b) begin
               count_in           = upd_count;
               tok_in_next.done   = 1'b1;
               tok_in_next.status = kcut_pkg::ST_OK;
               tok_in_next.value  = {{(kcut_pkg::VALUE_W-kcut_pkg::COUNT_W){1'b0}},
                                     upd_count};
            end
         end else if (key_b_ff == tok_in.key_b) begin
            if (tok_in.key_a == '0) begin
               tok_in_next.value = sat_sum;
            end else if (key_a_ff == tok_in.key_a) begin
               tok_in_next.done   = 1'b1;
               tok_in_next.status = kcut_pkg::ST_OK;
               tok_in_next.value  = {{(kcut_pkg::VALUE_W-kcut_pkg::COUNT_W){1'b0}},
                                     count_ff};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      key_a_ff <= key_a_in;
      count_ff <= count_in;
      if (reset) begin
         key_b_ff <= '0;
         tok_ff   <= '0;
      end else begin
         key_b_ff <= key_b_in;
         tok_ff   <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

[design/keyed_counter_upsert_table_core.sv]
// The request word is registered at launch, then in each entry cell in turn, and
// the outcome is registered as the response word. The request token walks the
// cell chain one entry per cycle, and a new request waits until the response
// word has been taken.
// Reset clears every entry's second key (all entries empty) and the control
// state; no clearing pass follows.
// ----------------------------------------------------------------------------
// Keyed counter table core
// Upsert and query of saturating counters held in a chain of entry cells.
// ----------------------------------------------------------------------------
module keyed_counter_upsert_table_core #(
   parameter int ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  kcut_pkg::kcut_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output kcut_pkg::kcut_rsp_type rsp_data
);

   kcut_pkg::kcut_token_type tok [ENTRIES+1];
   kcut_pkg::kcut_token_type launch_ff, launch_in;
   kcut_pkg::kcut_rsp_type   rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     busy_ff, busy_in;
   logic                     req_take, rsp_take;
   logic                     key_bad;
   kcut_pkg::kcut_token_type tail;

   assign req_take = req_valid && !busy_ff;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   // An add needs both key parts; a query needs only the second.
   assign key_bad = (req_data.key_b == '0)
                 || (req_data.func == kcut_pkg::FUNC_ADD && req_data.key_a == '0);

   always_comb begin
      launch_in.valid  = req_take;
      launch_in.done   = key_bad;
      launch_in.func   = req_data.func;
      launch_in.key_a  = req_data.key_a;
      launch_in.key_b  = req_data.key_b;
      launch_in.delta  = req_data.delta;
      launch_in.status = key_bad ? kcut_pkg::ST_INVALID : kcut_pkg::ST_OK;
      launch_in.value  = '0;
   end

   assign tok[0] = launch_ff;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      kcut_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_in (tok[i]),
         .tok_out(tok[i+1])
      );
   end

   assign tail = tok[ENTRIES];

   // A token that leaves the chain unserved is either a full table on an add,
   // or a query whose answer is the accumulated sum (zero when nothing matched).
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      busy_in      = busy_ff;
      if (rsp_take) begin
         busy_in = 1'b0;
      end
      if (tail.valid) begin
         rsp_valid_in = 1'b1;
         if (tail.done) begin
            rsp_in.status = tail.status;
            rsp_in.value  = tail.value;
         end else if (tail.func == kcut_pkg::FUNC_ADD) begin
            rsp_in.status = kcut_pkg::ST_FULL;
            rsp_in.value  = '0;
         end else begin
            rsp_in.status = kcut_pkg::ST_OK;
            rsp_in.value  = tail.value;
         end
      end
      if (req_take) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
      end
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/kcut_checker.sv]
// ----------------------------------------------------------------------------
// Keyed counter table checker
// Port-level checks on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module kcut_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input kcut_pkg::kcut_rsp_type rsp_data
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   // Only one request is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall && !rsp_valid)
      else $error("request accepted while another is in flight");

   // No request is accepted while a response word is waiting.
   a_no_take_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a response word waits");

   // Full table and invalid key report no count.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == kcut_pkg::ST_FULL
                 || rsp_data.status == kcut_pkg::ST_INVALID)
      |-> rsp_data.value == '0)
      else $error("failed request reports a non-zero value");

   // A new entry holds a single clamped count.
   a_new_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == kcut_pkg::ST_NEW
      |-> rsp_data.value[kcut_pkg::VALUE_W-1:kcut_pkg::COUNT_W] == '0)
      else $error("new entry count out of range");

endmodule

bind keyed_counter_upsert_table_core kcut_checker u_kcut_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

[tb/keyed_counter_upsert_table_core_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed counter table checker
// Watches both channels and keeps its own copy of the table. Each accepted
// request word is applied to that copy, and the reply it should produce is
// queued. Each accepted response word is compared with the oldest queued reply.
// ----------------------------------------------------------------------------
module keyed_counter_upsert_table_core_checker
   import kcut_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  kcut_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  kcut_rsp_type rsp_data,
   output int           fail_count,
   output int           due_count,
   output int           checked_count,
   output int           insert_count,
   output int           full_count,
   output int           invalid_count
);

   typedef struct packed {
      kcut_req_type req;
      kcut_rsp_type rsp;
   } reply_due_type;

   logic [KEY_W-1:0]   tbl_key_a [ENTRIES];
   logic [KEY_W-1:0]   tbl_key_b [ENTRIES];
   logic [COUNT_W-1:0] tbl_count [ENTRIES];
   reply_due_type      replies_due [$];

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_key_a[i] = '0;
         tbl_key_b[i] = '0;
         tbl_count[i] = '0;
      end
   end

   function automatic logic [COUNT_W-1:0] clamp_count(input int sum);
      if (sum < 0) return '0;
      if (sum > int'(COUNT_MAX)) return COUNT_MAX;
      return COUNT_W'(sum);
   endfunction

   // Applies one request to the table copy and returns the reply it earns.
   function automatic kcut_rsp_type apply_table_op(input kcut_req_type w);
      kcut_rsp_type r;
      int           free_slot;
      int           hit_slot;
      int           sum;
      r.status  = ST_INVALID;
      r.value   = '0;
      free_slot = -1;
      hit_slot  = -1;
      sum       = 0;
      if (w.func == FUNC_ADD) begin
         if (w.key_a != '0 && w.key_b != '0) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (hit_slot < 0) begin
                  if (tbl_key_b[i] == '0) begin
                     if (free_slot < 0) free_slot = i;
                  end else if (tbl_key_b[i] == w.key_b && tbl_key_a[i] == w.key_a) begin
                     hit_slot = i;
                  end
               end
            end
            if (hit_slot >= 0) begin
               tbl_count[hit_slot] = clamp_count(int'(tbl_count[hit_slot]) +
                                                 int'($signed(w.delta)));
               r.status = ST_OK;
               r.value  = VALUE_W'(tbl_count[hit_slot]);
            end else if (free_slot < 0) begin
               r.status = ST_FULL;
            end else begin
               tbl_key_a[free_slot] = w.key_a;
               tbl_key_b[free_slot] = w.key_b;
               tbl_count[free_slot] = clamp_count(int'($signed(w.delta)));
               r.status = ST_NEW;
               r.value  = VALUE_W'(tbl_count[free_slot]);
            end
         end
      end else if (w.key_b != '0) begin
         r.status = ST_OK;
         for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_key_b[i] == w.key_b) begin
               if (w.key_a == '0) begin
                  sum += int'(tbl_count[i]);
                  if (sum > int'(VALUE_MAX)) sum = int'(VALUE_MAX);
               end else if (hit_slot < 0 && tbl_key_a[i] == w.key_a) begin
                  hit_slot = i;
               end
            end
         end
         r.value = (hit_slot >= 0) ? VALUE_W'(tbl_count[hit_slot]) : VALUE_W'(sum);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reply_due_type due;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response word with nothing outstanding: status %0d value %0d",
                           $realtime, rsp_data.status, rsp_data.value);
               fail_count <= fail_count + 1;
            end else begin
               due = replies_due.pop_front();
               checked_count <= checked_count + 1;
               if (due.rsp.status == ST_NEW) insert_count <= insert_count + 1;
               if (due.rsp.status == ST_FULL) full_count <= full_count + 1;
               if (due.rsp.status == ST_INVALID) invalid_count <= invalid_count + 1;
               if (rsp_data.status !== due.rsp.status || rsp_data.value !== due.rsp.value) begin
                  if (fail_count < 10)
                     $display("%0t: func %0d key_a %h key_b %h delta %0d: ",
                              $realtime, due.req.func, due.req.key_a, due.req.key_b,
                              $signed(due.req.delta),
                              "status exp %0d got %0d, value exp %0d got %0d",
                              due.rsp.status, rsp_data.status,
                              due.rsp.value, rsp_data.value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            due.req = req_data;
            due.rsp = apply_table_op(req_data);
            replies_due.push_back(due);
         end
         due_count <= replies_due.size();
      end
   end

endmodule

[tb/keyed_counter_upsert_table_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed counter table testbench
// Drives directed and random add and query words into the table core while
// both channels idle at random in the first two random mixes, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module keyed_counter_upsert_table_core_tb;
   import kcut_pkg::*;

   localparam int ENTRIES      = 64;
   localparam int RANDOM_WORDS = 310;
   localparam int CYCLE_LIMIT  = 600000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   kcut_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   kcut_rsp_type rsp_data;

   int fail_count;
   int due_count;
   int checked_count;
   int insert_count;
   int full_count;
   int invalid_count;
   int cycle_count;
   int send_idle_pct;
   int rsp_stall_pct;
   int sent_count;

   keyed_counter_upsert_table_core #(
      .ENTRIES(ENTRIES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   keyed_counter_upsert_table_core_checker #(
      .ENTRIES(ENTRIES)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .due_count    (due_count),
      .checked_count(checked_count),
      .insert_count (insert_count),
      .full_count   (full_count),
      .invalid_count(invalid_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d replies outstanding.",
                  cycle_count, due_count);
         $display("keyed_counter_upsert_table_core_tb: errors");
         $finish;
      end
   end

   function automatic kcut_req_type make_word(input logic func, input logic [KEY_W-1:0] a,
                                              input logic [KEY_W-1:0] b, input int d);
      kcut_req_type w;
      w.func  = func;
      w.key_a = a;
      w.key_b = b;
      w.delta = COUNT_W'(d);
      return w;
   endfunction

   // Keys come mostly from a small pool so that entries are hit again; a few
   // are drawn across the whole range to exercise every key bit.
   function automatic kcut_req_type random_word(input int key_span, input int wide_pct);
      kcut_req_type w;
      int           pick;
      w.func = ($urandom_range(99) < 30) ? FUNC_QUERY : FUNC_ADD;
      pick = $urandom_range(99);
      if (pick < 10) w.key_a = '0;
      else if (pick < 10 + wide_pct) w.key_a = KEY_W'($urandom);
      else w.key_a = KEY_W'($urandom_range(key_span, 1));
      pick = $urandom_range(99);
      if (pick < 4) w.key_b = '0;
      else if (pick < 4 + wide_pct) w.key_b = KEY_W'($urandom);
      else w.key_b = KEY_W'($urandom_range(4, 1));
      pick = $urandom_range(99);
      if (pick < 40) w.delta = COUNT_W'($urandom_range(200) - 100);
      else if (pick < 65) w.delta = COUNT_W'($urandom);
      else if (pick < 80) w.delta = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      else w.delta = COUNT_W'($urandom_range(32767, 1000));
      return w;
   endfunction

   // Holds the word until it is taken, then perhaps leaves an idle gap of random
   // length so that gaps land on every part of the block's work.
   task automatic send_word(input kcut_req_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(2 * ENTRIES + 4, 1)) @(posedge clock);
      end
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table, invalid keys, insertion with clamping, saturation and sums.
      send_word(make_word(FUNC_QUERY, 16'h0001, 16'h0001, 0));
      send_word(make_word(FUNC_QUERY, 16'h0000, 16'h0001, 0));
      send_word(make_word(FUNC_QUERY, 16'h0001, 16'h0000, 5));
      send_word(make_word(FUNC_ADD,   16'h0000, 16'h0001, 10));
      send_word(make_word(FUNC_ADD,   16'h0001, 16'h0000, 10));
      send_word(make_word(FUNC_ADD,   16'h0000, 16'h0000, 32767));
      send_word(make_word(FUNC_ADD,   16'h0001, 16'h0001, 100));
      send_word(make_word(FUNC_ADD,   16'h0001, 16'h0001, -30));
      send_word(make_word(FUNC_ADD,   16'h0001, 16'h0001, -32768));
      send_word(make_word(FUNC_ADD,   16'h0002, 16'h0001, -5));
      send_word(make_word(FUNC_ADD,   16'hFFFF, 16'hFFFF, 32767));
      send_word(make_word(FUNC_ADD,   16'hFFFF, 16'hFFFF, 32767));
      send_word(make_word(FUNC_ADD,   16'hFFFF, 16'hFFFF, 32767));
      send_word(make_word(FUNC_ADD,   16'h0003, 16'h0001, 32767));
      send_word(make_word(FUNC_ADD,   16'h0001, 16'hFFFF, 1234));
      send_word(make_word(FUNC_QUERY, 16'h0000, 16'h0001, 0));
      send_word(make_word(FUNC_QUERY, 16'hFFFF, 16'hFFFF, -1));
      send_word(make_word(FUNC_QUERY, 16'h0009, 16'h0001, 0));
      send_word(make_word(FUNC_QUERY, 16'h0001, 16'h0001, -32768));
      send_word(make_word(FUNC_ADD,   16'h0001, 16'h0001, 0));
      send_word(make_word(FUNC_QUERY, 16'h0000, 16'hFFFF, 32767));
      send_word(make_word(FUNC_QUERY, 16'h0000, 16'h0002, 0));
      drain_replies();

      // The second mix widens the key pool until the table fills; the last
      // runs against a full table with no idling at all.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct <= 9;
               rsp_stall_pct <= 56;
            end
            1: begin
               send_idle_pct <= 56;
               rsp_stall_pct <= 9;
            end
            default: begin
               send_idle_pct <= 0;
               rsp_stall_pct <= 0;
            end
         endcase
         for (int n = 0; n < RANDOM_WORDS; n++) begin
            case (phase)
               0: send_word(random_word(5, 3));
               1: send_word(random_word(16, 10));
               default: send_word(random_word(6, 10));
            endcase
         end
         drain_replies();
      end

      repeat (ENTRIES + 8) @(posedge clock);
      $display("Sent %0d request words and checked %0d response words.",
               sent_count, checked_count);
      $display("Replies seen: %0d inserts, %0d table full, %0d invalid key, %0d others.",
               insert_count, full_count, invalid_count,
               checked_count - insert_count - full_count - invalid_count);
      if (fail_count == 0 && due_count == 0) begin
         $display("keyed_counter_upsert_table_core_tb: clean");
      end else begin
         $display("keyed_counter_upsert_table_core_tb: errors");
      end
      $finish;
   end

endmodule

[files.f]
design/kcut_pkg.sv
design/kcut_cell.sv
design/keyed_counter_upsert_table_core.sv
design/kcut_checker.sv
tb/keyed_counter_upsert_table_core_checker.sv
tb/keyed_counter_upsert_table_core_tb.sv
